// ===== rtl/core/multichannel_sample_history_average_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the multichannel sample history average unit
// Clocked on clk; MSHAU_ASSERT is masked during reset.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_SAMPLE_HISTORY_AVERAGE_UNIT_MACROS_SVH
`define MULTICHANNEL_SAMPLE_HISTORY_AVERAGE_UNIT_MACROS_SVH

// Property checked at every edge outside reset.
`define MSHAU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define MSHAU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/mshau_pkg.sv =====
// ----------------------------------------------------------------------------
// mshau_pkg
// Types and constants shared by the sample history average unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mshau_pkg;

    localparam int CHANNELS      = 16;
    localparam int HISTORY_DEPTH = 8;
    localparam int SAMPLE_BITS   = 10;

    localparam int CH_BITS   = $clog2(CHANNELS);
    localparam int SLOT_BITS = $clog2(HISTORY_DEPTH);
    localparam int ADDR_BITS = CH_BITS + SLOT_BITS;
    localparam int ENTRIES   = CHANNELS * HISTORY_DEPTH;
    localparam int SUM_BITS  = SAMPLE_BITS + SLOT_BITS;

    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_READ  = 1'b1
    } action_t;

    typedef struct packed {
        action_t                action;
        logic [CH_BITS-1:0]     channel;
        logic [SAMPLE_BITS-1:0] sample;
        logic [SLOT_BITS-1:0]   slot_index;
    } req_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] mean_value;
        logic [SAMPLE_BITS-1:0] newest_value;
        logic [SAMPLE_BITS-1:0] slot_value;
    } rsp_t;

    typedef struct packed {
        logic                 en;
        logic [ADDR_BITS-1:0] addr_a;
        logic [ADDR_BITS-1:0] addr_b;
    } ram_rd_t;

    typedef struct packed {
        logic                   en;
        logic [ADDR_BITS-1:0]   addr;
        logic [SAMPLE_BITS-1:0] data;
    } ram_wr_t;

endpackage

// ===== rtl/core/mshau_sample_ram.sv =====
// ----------------------------------------------------------------------------
// mshau_sample_ram
// Sample store: one write port, two registered read ports, per-entry valid
// bits so unwritten entries read as zero, write-to-read bypass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mshau_sample_ram (
    input  logic                             clk,
    input  logic                             rst_n,
    input  mshau_pkg::ram_rd_t               rd,
    input  mshau_pkg::ram_wr_t               wr,
    output logic [mshau_pkg::SAMPLE_BITS-1:0] rd_data_a,
    output logic [mshau_pkg::SAMPLE_BITS-1:0] rd_data_b
);
    import mshau_pkg::*;

    logic [SAMPLE_BITS-1:0] mem [ENTRIES];
    logic [ENTRIES-1:0]     entry_valid_reg;

    logic [SAMPLE_BITS-1:0] rd_a_reg;
    logic [SAMPLE_BITS-1:0] rd_b_reg;
    logic [SAMPLE_BITS-1:0] fwd_data_reg;
    logic                   valid_a_reg;
    logic                   valid_b_reg;
    logic                   fwd_a_reg;
    logic                   fwd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_a_reg     <= mem[rd.addr_a];
            rd_b_reg     <= mem[rd.addr_b];
            fwd_data_reg <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            valid_a_reg     <= 1'b0;
            valid_b_reg     <= 1'b0;
            fwd_a_reg       <= 1'b0;
            fwd_b_reg       <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                entry_valid_reg[wr.addr] <= 1'b1;
            end
            if (rd.en)
            begin
                valid_a_reg <= entry_valid_reg[rd.addr_a];
                valid_b_reg <= entry_valid_reg[rd.addr_b];
                fwd_a_reg   <= wr.en && (wr.addr == rd.addr_a);
                fwd_b_reg   <= wr.en && (wr.addr == rd.addr_b);
            end
        end
    end

    always_comb
    begin
        if (fwd_a_reg)
            rd_data_a = fwd_data_reg;
        else if (valid_a_reg)
            rd_data_a = rd_a_reg;
        else
            rd_data_a = '0;

        if (fwd_b_reg)
            rd_data_b = fwd_data_reg;
        else if (valid_b_reg)
            rd_data_b = rd_b_reg;
        else
            rd_data_b = '0;
    end

endmodule

// ===== rtl/core/multichannel_sample_history_average_unit.sv =====
// ----------------------------------------------------------------------------
// multichannel_sample_history_average_unit
// Eight-sample history per channel with running mean, newest and slot read.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one beat per item. A write beat (action ACT_WRITE) stores the
//   sample at the channel's write pointer and advances it; it gives no rsp.
//   A read beat (ACT_READ) gives one rsp beat: mean of the eight slots, the
//   newest written sample, and the sample in slot_index.
//   Path: a read beat is accepted into s1 as the sample store read registers
//   load; the output register loads when s1 advances, which waits while rsp
//   is held, and rsp_valid is set as the output register loads.
//   Throughput: one beat per cycle while rsp is not held, set by the single
//   read-modify-write pass through the sample store; a write feeding the next
//   beat's read of the same entry is bypassed, so that does not stall beats.
//   Reset: the store, write pointers and running sums read as zero, with no
//   clearing pass; beats are taken from the first edge after reset.
//   Stall: while rsp is held, a read beat waiting behind it holds req_ready
//   low; write beats still drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "multichannel_sample_history_average_unit_macros.svh"

module multichannel_sample_history_average_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  mshau_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output mshau_pkg::rsp_t rsp
);
    import mshau_pkg::*;

    logic [SLOT_BITS-1:0]   ptr_reg [CHANNELS];
    logic [SUM_BITS-1:0]    sum_reg [CHANNELS];

    logic                   s1_valid_reg;
    logic                   s1_write_reg;
    logic [CH_BITS-1:0]     s1_channel_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;
    logic [SLOT_BITS-1:0]   s1_ptr_reg;

    logic                   rsp_valid_reg;
    rsp_t                   rsp_reg;

    logic                   req_fire;
    logic                   s1_adv;
    logic [SLOT_BITS-1:0]   cur_ptr;
    logic [SLOT_BITS-1:0]   prev_ptr;
    logic [SUM_BITS-1:0]    cur_sum;
    logic [SUM_BITS-1:0]    sum_next;
    ram_rd_t                ram_rd;
    ram_wr_t                ram_wr;
    logic [SAMPLE_BITS-1:0] rd_data_a;
    logic [SAMPLE_BITS-1:0] rd_data_b;

    assign s1_adv    = s1_valid_reg && (s1_write_reg || !rsp_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || s1_adv;
    assign req_fire  = req_valid && req_ready;

    assign cur_ptr  = ptr_reg[req.channel];
    assign prev_ptr = cur_ptr - SLOT_BITS'(1);
    assign cur_sum  = sum_reg[s1_channel_reg];
    assign sum_next = cur_sum - SUM_BITS'(rd_data_a) + SUM_BITS'(s1_sample_reg);

    always_comb
    begin
        ram_rd.en     = req_fire;
        ram_rd.addr_a = (req.action == ACT_WRITE) ? {req.channel, cur_ptr}
                                                  : {req.channel, prev_ptr};
        ram_rd.addr_b = {req.channel, req.slot_index};

        ram_wr.en     = s1_adv && s1_write_reg;
        ram_wr.addr   = {s1_channel_reg, s1_ptr_reg};
        ram_wr.data   = s1_sample_reg;
    end

    mshau_sample_ram u_sample_ram (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd        (ram_rd),
        .wr        (ram_wr),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                ptr_reg[i] <= '0;
                sum_reg[i] <= '0;
            end
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_fire && (req.action == ACT_WRITE))
            begin
                ptr_reg[req.channel] <= cur_ptr + SLOT_BITS'(1);
            end
            if (ram_wr.en)
            begin
                sum_reg[s1_channel_reg] <= sum_next;
            end

            if (req_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv && !s1_write_reg)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_write_reg   <= (req.action == ACT_WRITE);
            s1_channel_reg <= req.channel;
            s1_sample_reg  <= req.sample;
            s1_ptr_reg     <= cur_ptr;
        end
        if (s1_adv && !s1_write_reg)
        begin
            rsp_reg.mean_value   <= SAMPLE_BITS'(cur_sum >> SLOT_BITS);
            rsp_reg.newest_value <= rd_data_a;
            rsp_reg.slot_value   <= rd_data_b;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `MSHAU_ASSERT(a_ready_low_only_on_held_read, !req_ready |-> s1_valid_reg && !s1_write_reg && rsp_valid_reg && !rsp_ready, "req_ready low without a blocked read")
    `MSHAU_ASSERT(a_write_gives_no_rsp, s1_valid_reg && s1_write_reg && !rsp_valid_reg |=> !rsp_valid_reg, "write beat produced a response")
    `MSHAU_ASSERT(a_blocked_read_holds, s1_valid_reg && !s1_write_reg && rsp_valid_reg && !rsp_ready |=> s1_valid_reg && !s1_write_reg && $stable(s1_channel_reg), "blocked read beat lost")
    `MSHAU_ASSERT_ALWAYS(a_idle_in_reset, !rst_n |=> !rsp_valid_reg && !s1_valid_reg, "pipeline busy after a reset edge")

endmodule
